// ===== src/gpm_pkg.sv =====
package gpm_pkg;

    // Number of pins that take part in events and change reporting.
    localparam int unsigned PIN_COUNT = 16;

    // Request kinds.
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_EVENT = 2'd2;

    // Byte offsets of the register window.
    localparam logic [9:0] OFS_CRL  = 10'd0;
    localparam logic [9:0] OFS_CRH  = 10'd4;
    localparam logic [9:0] OFS_IDR  = 10'd8;
    localparam logic [9:0] OFS_ODR  = 10'd12;
    localparam logic [9:0] OFS_BSRR = 10'd16;
    localparam logic [9:0] OFS_BRR  = 10'd20;
    localparam logic [9:0] OFS_LCKR = 10'd24;

    // Error codes.
    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_ACCESS   = 2'd1;
    localparam logic [1:0] ERR_CONFLICT = 2'd2;

    localparam logic [31:0] CFG_RESET = 32'h4444_4444;
    localparam logic [16:0] LOCK_MASK = 17'h1_FFFF;

    typedef struct packed {
        logic [1:0]  func;
        logic [9:0]  reg_offset;
        logic [31:0] write_data;
        logic [3:0]  pin;
        logic        level;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] out_change_mask;
        logic [15:0] out_levels;
        logic        analog_valid;
        logic [3:0]  analog_pin;
        logic        analog_level;
        logic [1:0]  error_code;
    } rsp_t;

    // Four-bit configuration field of one pin.
    function automatic logic [3:0] pin_field(input logic [31:0] crl, input logic [31:0] crh,
                                             input logic [3:0] pin);
        logic [31:0] word;
        begin
            word = pin[3] ? crh : crl;
            return word[{pin[2:0], 2'b00} +: 4];
        end
    endfunction

endpackage

// ===== src/gpm_req_if.sv =====
interface gpm_req_if
    import gpm_pkg::*;
();
    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== src/gpm_rsp_if.sv =====
interface gpm_rsp_if
    import gpm_pkg::*;
();
    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== src/gpio_port_register_model_unit.sv =====
// Channel  | Direction | Carries
// ---------+-----------+-----------------------------------------------------
// req      | sink      | one bus read, bus write or pin event per request
// rsp      | source    | exactly one result per request, in request order
//
// A request is taken into an input register; once the result register is empty
// or being drained, the decode logic updates the port registers and loads it.
// One request is accepted in every cycle while rsp is not stalled.
// The result register may hold a result while the input register holds the
// next request, so a stall on rsp reaches req only when both are full.
// Reset (rst_n low) sets both configuration words to 0x44444444, clears the
// data and lock registers and empties both stages.
module gpio_port_register_model_unit
    import gpm_pkg::*;
#(
    parameter int unsigned PIN_COUNT = gpm_pkg::PIN_COUNT
)
(
    input  logic       clk,
    input  logic       rst_n,
    gpm_req_if.sink    req,
    gpm_rsp_if.source  rsp
);

    // Input stage.
    logic        in_valid_reg;
    req_t        in_reg;

    // Port registers.
    logic [31:0] crl_reg, crl_next;
    logic [31:0] crh_reg, crh_next;
    logic [15:0] idr_reg, idr_next;
    logic [15:0] odr_reg, odr_next;
    logic [16:0] lck_reg, lck_next;

    // Result stage.
    logic        out_valid_reg;
    rsp_t        out_reg, out_next;

    logic        fire;

    // The result register can take a new result when it is empty or being drained.
    assign fire      = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || fire;

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_reg <= req.payload;
        end
    end

    // Decode of one request against the current port registers.
    always_comb
    begin
        logic [3:0]  field;
        logic [15:0] diff;
        logic [15:0] outputs;

        crl_next = crl_reg;
        crh_next = crh_reg;
        idr_next = idr_reg;
        odr_next = odr_reg;
        lck_next = lck_reg;

        out_next = '0;
        field    = pin_field(crl_reg, crh_reg, in_reg.pin);

        // Pins whose mode field is nonzero drive their level.
        for (int i = 0; i < 16; i++)
        begin
            outputs[i] = (i < PIN_COUNT) && ((crl_reg[(i % 8) * 4 +: 2] != 2'b00 && i < 8) ||
                                             (crh_reg[(i % 8) * 4 +: 2] != 2'b00 && i >= 8));
        end
        diff = odr_reg ^ in_reg.write_data[15:0];

        case (in_reg.func)
            FUNC_READ:
            begin
                unique case (in_reg.reg_offset)
                    OFS_CRL:  out_next.read_data = crl_reg;
                    OFS_CRH:  out_next.read_data = crh_reg;
                    OFS_IDR:  out_next.read_data = {16'd0, idr_reg};
                    OFS_ODR:  out_next.read_data = {16'd0, odr_reg};
                    OFS_LCKR: out_next.read_data = {15'd0, lck_reg};
                    default:  out_next.error_code = ERR_ACCESS;
                endcase
            end
            FUNC_WRITE:
            begin
                unique case (in_reg.reg_offset)
                    OFS_CRL:  crl_next = in_reg.write_data;
                    OFS_CRH:  crh_next = in_reg.write_data;
                    OFS_ODR:
                    begin
                        odr_next                 = in_reg.write_data[15:0];
                        out_next.out_change_mask = diff & outputs;
                    end
                    OFS_BSRR, OFS_BRR:
                    begin
                        // Accepted without effect.
                    end
                    OFS_LCKR: lck_next = in_reg.write_data[16:0] & LOCK_MASK;
                    default:  out_next.error_code = ERR_ACCESS;
                endcase
            end
            FUNC_EVENT:
            begin
                if ({28'd0, in_reg.pin} < PIN_COUNT)
                begin
                    if (field[1:0] != 2'b00)
                    begin
                        out_next.error_code = ERR_CONFLICT;
                    end
                    else if (field[3:2] != 2'b00)
                    begin
                        idr_next[in_reg.pin] = in_reg.level;
                    end
                    else
                    begin
                        out_next.analog_valid = 1'b1;
                        out_next.analog_pin   = in_reg.pin;
                        out_next.analog_level = in_reg.level;
                    end
                end
            end
            default:
            begin
                // Unused request kind: ignored.
            end
        endcase

        out_next.out_levels = odr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crl_reg <= CFG_RESET;
            crh_reg <= CFG_RESET;
            idr_reg <= '0;
            odr_reg <= '0;
            lck_reg <= '0;
        end
        else if (fire)
        begin
            crl_reg <= crl_next;
            crh_reg <= crh_next;
            idr_reg <= idr_next;
            odr_reg <= odr_next;
            lck_reg <= lck_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTH
    // A held request is never dropped while the result register is blocked.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg)
        else $error("input stage lost a request");

    // The reported levels always match the output data register.
    a_levels: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.out_levels == odr_reg)
        else $error("result levels differ from output data");

    // A forwarded analog event never carries an error.
    a_analog_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.analog_valid |-> out_reg.error_code == ERR_OK)
        else $error("analog event reported with an error");

    // Change reporting only comes with a clean write that reads nothing.
    a_change_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.out_change_mask != '0 |->
            out_reg.error_code == ERR_OK && out_reg.read_data == '0)
        else $error("change mask on a non-write result");

    // The port registers only move when a result is produced.
    a_state_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(odr_reg) && $stable(idr_reg) && $stable(crl_reg))
        else $error("port registers changed without a request");
`endif

endmodule

// ===== tb/gpio_port_register_model_unit_tb.sv =====
`timescale 1ns / 1ps

module gpio_port_register_model_unit_tb;

    import gpm_pkg::*;

    // The fourth request kind is unused by the port and must be ignored by it.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Number of random requests sent after the directed ones.
    localparam int unsigned RANDOM_REQUESTS = 1525;

    // Once no more than this many requests remain to be sent, neither side starts a new idle burst.
    localparam int unsigned TAIL_REQUESTS = 150;

    // Cycles allowed for stray results after the last expected one has arrived.
    localparam int unsigned DRAIN_CYCLES = 10;

    logic clk = 1'b0;
    logic rst_n;

    gpm_req_if req_bus ();
    gpm_rsp_if rsp_bus ();

    gpio_port_register_model_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Requests waiting to be offered to the port, and the results that the
    // requests already accepted must produce, oldest first.
    req_t pending_requests[$];
    rsp_t expected_results[$];

    // Our own view of the port registers, advanced once per accepted request.
    logic [31:0] cfg_lo;
    logic [31:0] cfg_hi;
    logic [15:0] in_levels;
    logic [15:0] out_latch;
    logic [16:0] lock_bits;

    int unsigned errors = 0;
    int unsigned requests_accepted = 0;
    int unsigned results_checked = 0;
    int unsigned seen_conflicts = 0;
    int unsigned seen_analog = 0;
    int unsigned seen_access_errors = 0;
    int unsigned seen_level_changes = 0;

    // Lengths of the idle and stall bursts still to run on each side.
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard limit on the run. A correct run with the longest gaps and stalls on
    // every request needs well under half a millisecond.
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic req_t make_req(input logic [1:0] f, input logic [9:0] ofs,
                                      input logic [31:0] d, input logic [3:0] p,
                                      input logic lv);
        req_t r;
        r.func       = f;
        r.reg_offset = ofs;
        r.write_data = d;
        r.pin        = p;
        r.level      = lv;
        return r;
    endfunction

    // One of the seven documented offsets, the set and reset registers included.
    function automatic logic [9:0] pick_offset();
        case ($urandom_range(0, 6))
            0: return OFS_CRL;
            1: return OFS_CRH;
            2: return OFS_IDR;
            3: return OFS_ODR;
            4: return OFS_BSRR;
            5: return OFS_BRR;
            default: return OFS_LCKR;
        endcase
    endfunction

    // Four-bit configuration field of a pin: bits 1..0 hold the mode, where
    // anything nonzero makes the pin an output, and bits 3..2 the input kind,
    // where zero means analog.
    function automatic logic [3:0] cfg_nibble(input int unsigned p);
        logic [31:0] word;
        word = (p < 8) ? cfg_lo : cfg_hi;
        return word[4 * (p % 8) +: 4];
    endfunction

    // Applies one request to our copy of the port registers and returns the
    // result that the port must give for it.
    function automatic rsp_t apply_request(input req_t r);
        rsp_t        o;
        logic [15:0] changed;
        logic [3:0]  field;
        int unsigned i;
        o = '0;
        case (r.func)
            FUNC_READ:
            begin
                case (r.reg_offset)
                    OFS_CRL:  o.read_data = cfg_lo;
                    OFS_CRH:  o.read_data = cfg_hi;
                    OFS_IDR:  o.read_data = {16'h0000, in_levels};
                    OFS_ODR:  o.read_data = {16'h0000, out_latch};
                    OFS_LCKR: o.read_data = {15'h0000, lock_bits};
                    // The set and reset registers read as forbidden, as does
                    // any offset outside the window.
                    default:  o.error_code = ERR_ACCESS;
                endcase
            end
            FUNC_WRITE:
            begin
                case (r.reg_offset)
                    OFS_CRL:  cfg_lo = r.write_data;
                    OFS_CRH:  cfg_hi = r.write_data;
                    OFS_ODR:
                    begin
                        changed   = out_latch ^ r.write_data[15:0];
                        out_latch = r.write_data[15:0];
                        for (i = 0; i < 16; i++)
                        begin
                            field = cfg_nibble(i);
                            if (i < PIN_COUNT && field[1:0] != 2'b00 && changed[i])
                                o.out_change_mask[i] = 1'b1;
                        end
                    end
                    // Writes to the set and reset registers are taken but change nothing.
                    OFS_BSRR, OFS_BRR: ;
                    OFS_LCKR: lock_bits = r.write_data[16:0];
                    // The input data register is read only.
                    default:  o.error_code = ERR_ACCESS;
                endcase
            end
            FUNC_EVENT:
            begin
                if (r.pin < PIN_COUNT)
                begin
                    field = cfg_nibble(r.pin);
                    if (field[1:0] != 2'b00)
                        o.error_code = ERR_CONFLICT;
                    else if (field[3:2] != 2'b00)
                        in_levels[r.pin] = r.level;
                    else
                    begin
                        o.analog_valid = 1'b1;
                        o.analog_pin   = r.pin;
                        o.analog_level = r.level;
                    end
                end
            end
            default: ;
        endcase
        o.out_levels = out_latch;
        return o;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // Request driver. A request is predicted at the edge where the port takes
    // it; the next one is then offered unless an idle burst is running.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_bus.valid   <= 1'b0;
            req_bus.payload <= '0;
            send_gap = 0;
            cfg_lo    = CFG_RESET;
            cfg_hi    = CFG_RESET;
            in_levels = '0;
            out_latch = '0;
            lock_bits = '0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
            begin
                expected_results.push_back(apply_request(req_bus.payload));
                requests_accepted++;
            end
            // A request still waiting for ready is held as it stands.
            if (!req_bus.valid || req_bus.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_bus.valid <= 1'b0;
                end
                else if (pending_requests.size() > TAIL_REQUESTS && $urandom_range(0, 5) == 0)
                begin
                    send_gap = $urandom_range(1, 10) - 1;
                    req_bus.valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    req_bus.payload <= pending_requests.pop_front();
                    req_bus.valid   <= 1'b1;
                end
                else
                    req_bus.valid <= 1'b0;
            end
        end
    end

    // Result monitor. Every result taken is compared, field by field, with the
    // oldest outstanding expectation; ready is dropped in random bursts.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result 0x%0h arrived with no request outstanding", rsp_bus.payload);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("read_data", want.read_data, rsp_bus.payload.read_data);
                    check_field("out_change_mask", 32'(want.out_change_mask),
                                32'(rsp_bus.payload.out_change_mask));
                    check_field("out_levels", 32'(want.out_levels),
                                32'(rsp_bus.payload.out_levels));
                    check_field("analog_valid", 32'(want.analog_valid),
                                32'(rsp_bus.payload.analog_valid));
                    check_field("analog_pin", 32'(want.analog_pin),
                                32'(rsp_bus.payload.analog_pin));
                    check_field("analog_level", 32'(want.analog_level),
                                32'(rsp_bus.payload.analog_level));
                    check_field("error_code", 32'(want.error_code),
                                32'(rsp_bus.payload.error_code));
                    results_checked++;
                    if (want.error_code == ERR_CONFLICT)
                        seen_conflicts++;
                    if (want.error_code == ERR_ACCESS)
                        seen_access_errors++;
                    if (want.analog_valid)
                        seen_analog++;
                    if (want.out_change_mask != '0)
                        seen_level_changes++;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end
            else if (pending_requests.size() > TAIL_REQUESTS && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                rsp_bus.ready <= 1'b0;
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    // Main sequence: fill the request queue, run reset, then wait for every
    // expected result before closing the run.
    initial
    begin
        req_t        r;
        int unsigned counted;
        int unsigned pick;
        int unsigned n;
        logic [31:0] word;

        req_bus.valid   = 1'b0;
        req_bus.payload = '0;
        rsp_bus.ready   = 1'b0;
        rst_n           = 1'b0;

        // Directed part. First every register is read in its reset state, and
        // the set and reset registers are read, which is forbidden.
        pending_requests.push_back(make_req(FUNC_READ, OFS_CRL, 32'hFFFF_FFFF, 4'd15, 1'b1));
        pending_requests.push_back(make_req(FUNC_READ, OFS_CRH, '0, '0, 1'b0));
        pending_requests.push_back(make_req(FUNC_READ, OFS_IDR, '0, '0, 1'b0));
        pending_requests.push_back(make_req(FUNC_READ, OFS_ODR, '0, '0, 1'b0));
        pending_requests.push_back(make_req(FUNC_READ, OFS_LCKR, '0, '0, 1'b0));
        pending_requests.push_back(make_req(FUNC_READ, OFS_BSRR, '0, '0, 1'b0));
        pending_requests.push_back(make_req(FUNC_READ, OFS_BRR, '0, '0, 1'b0));
        // The input data register cannot be written; the lock word keeps 17 bits.
        pending_requests.push_back(make_req(FUNC_WRITE, OFS_IDR, 32'hFFFF_FFFF, '0, 1'b0));
        pending_requests.push_back(make_req(FUNC_WRITE, OFS_LCKR, 32'hFFFF_FFFF, '0, 1'b0));
        pending_requests.push_back(make_req(FUNC_READ, OFS_LCKR, '0, '0, 1'b0));
        // Pins 0 to 7 become outputs. The high word mixes the three kinds:
        // pins 8, 9, 13 and 15 analog, 10 and 11 outputs, 12 and 14 digital.
        pending_requests.push_back(make_req(FUNC_WRITE, OFS_CRL, 32'h3333_3333, '0, 1'b0));
        pending_requests.push_back(make_req(FUNC_WRITE, OFS_CRH, 32'h0804_3100, '0, 1'b0));
        // Every output level toggles, upper data bits being dropped, then back.
        pending_requests.push_back(make_req(FUNC_WRITE, OFS_ODR, 32'hFFFF_FFFF, '0, 1'b0));
        pending_requests.push_back(make_req(FUNC_WRITE, OFS_ODR, 32'h0000_0000, '0, 1'b0));
        // Set and reset writes are taken but leave the output data alone.
        pending_requests.push_back(make_req(FUNC_WRITE, OFS_BSRR, 32'hFFFF_FFFF, '0, 1'b0));
        pending_requests.push_back(make_req(FUNC_WRITE, OFS_BRR, 32'hFFFF_FFFF, '0, 1'b0));
        // Pin events: a conflict on an output, two digital inputs going high,
        // and two analog inputs that must be forwarded.
        pending_requests.push_back(make_req(FUNC_EVENT, '0, '0, 4'd0, 1'b1));
        pending_requests.push_back(make_req(FUNC_EVENT, '0, '0, 4'd12, 1'b1));
        pending_requests.push_back(make_req(FUNC_EVENT, '0, '0, 4'd14, 1'b1));
        pending_requests.push_back(make_req(FUNC_EVENT, '0, '0, 4'd8, 1'b1));
        pending_requests.push_back(make_req(FUNC_EVENT, '0, '0, 4'd15, 1'b0));
        pending_requests.push_back(make_req(FUNC_READ, OFS_IDR, '0, '0, 1'b0));
        // Offsets outside the window, and the unused request kind.
        pending_requests.push_back(make_req(FUNC_READ, 10'd1023, '0, '0, 1'b0));
        pending_requests.push_back(make_req(FUNC_WRITE, 10'd2, 32'hFFFF_FFFF, '0, 1'b0));
        pending_requests.push_back(make_req(FUNC_UNUSED, 10'd1023, 32'hFFFF_FFFF, 4'd15, 1'b1));

        // Random part. Every field starts fully random so that all bits toggle,
        // then the request is steered towards the interesting kinds. Most
        // configuration writes are built pin by pin so that outputs, digital
        // inputs and analog inputs stay mixed and pin events reach all paths.
        counted = 0;
        while (counted < RANDOM_REQUESTS)
        begin
            r = make_req(FUNC_READ, 10'($urandom_range(0, 1023)), $urandom,
                         4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                r.func       = FUNC_WRITE;
                r.reg_offset = $urandom_range(0, 1) ? OFS_CRH : OFS_CRL;
                if ($urandom_range(0, 9) != 0)
                begin
                    for (n = 0; n < 8; n++)
                    begin
                        case ($urandom_range(0, 2))
                            0: word[4 * n +: 4] = {2'($urandom), 2'($urandom_range(1, 3))};
                            1: word[4 * n +: 4] = {2'($urandom_range(1, 3)), 2'b00};
                            default: word[4 * n +: 4] = 4'h0;
                        endcase
                    end
                    r.write_data = word;
                end
            end
            else if (pick < 30)
            begin
                r.func       = FUNC_WRITE;
                r.reg_offset = OFS_ODR;
            end
            else if (pick < 60)
                r.func = FUNC_EVENT;
            else if (pick < 75)
                r.reg_offset = pick_offset();
            else if (pick < 83)
            begin
                r.func       = FUNC_WRITE;
                r.reg_offset = pick_offset();
            end
            else if (pick < 95)
                r.func = $urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ;
            else
                r.func = FUNC_UNUSED;
            pending_requests.push_back(r);
            counted++;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Sampled on the falling edge, where everything driven at the rising
        // edge has settled.
        @(negedge clk);
        while (pending_requests.size() != 0 || req_bus.valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Ran %0d requests (reads, writes, pin events, unused kinds), %0d results checked.",
                 requests_accepted, results_checked);
        $display("Seen: %0d conflicts, %0d analog forwards, %0d access errors, %0d level changes.",
                 seen_conflicts, seen_analog, seen_access_errors, seen_level_changes);
        if (errors == 0 && expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
